>>> rtl/double_threshold_trigger_assert.svh
// assertion macros for the double threshold trigger
`ifndef DOUBLE_THRESHOLD_TRIGGER_ASSERT_SVH
`define DOUBLE_THRESHOLD_TRIGGER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DTT_ASSERT_NOW(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
		else $error("dtt assertion failed");

// next-cycle implication, checked outside reset
`define DTT_ASSERT_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
		else $error("dtt assertion failed");

`endif

>>> rtl/dtt_pkg.sv
// shared constants for the double threshold trigger
package dtt_pkg;

	localparam int CFG_IDX_BITS = 3;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [1:0] phase_t;

	localparam cfg_idx_t REG_UPPER    = 3'd0;
	localparam cfg_idx_t REG_LOWER    = 3'd1;
	localparam cfg_idx_t REG_PRE      = 3'd2;
	localparam cfg_idx_t REG_POST     = 3'd3;
	localparam cfg_idx_t REG_DEBOUNCE = 3'd4;
	localparam cfg_idx_t REG_MIN_RUN  = 3'd5;
	localparam cfg_idx_t REG_MAX_WIN  = 3'd6;
	localparam cfg_idx_t REG_REC_LEN  = 3'd7;

	localparam phase_t PH_IDLE     = 2'd0;
	localparam phase_t PH_DEBOUNCE = 2'd1;
	localparam phase_t PH_UPPER    = 2'd2;
	localparam phase_t PH_LOWER    = 2'd3;

endpackage

>>> rtl/dtt_if.sv
// stream and configuration channel interfaces for the double threshold trigger

interface dtt_sample_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          record_start;
	modport source (output valid, sample, record_start, input ready);
	modport sink (input valid, sample, record_start, output ready);
endinterface

interface dtt_window_if #(parameter int INDEX_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] window_start;
	logic [INDEX_BITS-1:0] window_end;
	logic [INDEX_BITS-1:0] window_number;
	logic                  limit_reached;
	modport source (output valid, window_start, window_end, window_number, limit_reached,
		input ready);
	modport sink (input valid, window_start, window_end, window_number, limit_reached,
		output ready);
endinterface

interface dtt_cfg_if #(parameter int DATA_BITS = 17, parameter int IDX_BITS = 3);
	logic                 valid;
	logic                 ready;
	logic [IDX_BITS-1:0]  index;
	logic [DATA_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/double_threshold_trigger.sv
// double threshold trigger: a sample passes the input register and then the result register before its window transfer
// throughput one sample per cycle; input register, one logic level, result register
// the result register stalls the input register only while a window waits on the output
// asynchronous active-low reset clears the configuration registers to their defaults (record length
// at its maximum) and all running state; the first sample after reset is index 0
module double_threshold_trigger import dtt_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int INDEX_BITS  = 16
) (
	input logic         clk,
	input logic         arst_n,
	dtt_sample_if.sink  samples,
	dtt_window_if.source windows,
	dtt_cfg_if.sink     cfg
);

	localparam int IB = INDEX_BITS;
	localparam int SB = SAMPLE_BITS;

	// configuration registers
	logic signed [SB-1:0] upper_q, lower_q;
	logic [IB-1:0]        pre_q, post_q, min_run_q, max_win_q;
	logic                 debounce_q;
	logic [IB:0]          rec_len_q;

	// input register
	logic                 valid_s1;
	logic signed [SB-1:0] sample_s1;
	logic                 rs_s1;

	// running state
	logic signed [SB-1:0] prev_q;
	logic                 have_prev_q;
	logic [IB:0]          pos_q;
	phase_t               phase_q;
	logic [IB-1:0]        run_q;
	logic [IB-1:0]        pend_q;
	logic                 have_emit_q;
	logic [IB-1:0]        emit_end_q;
	logic [IB-1:0]        count_q;
	logic                 halted_q;

	// result register
	logic          out_valid_q;
	logic [IB-1:0] wstart_q, wend_q, wnum_q;
	logic          limit_q;

	logic advance;

	// values of the running state after an optional record restart
	logic signed [SB-1:0] e_prev;
	logic                 e_have_prev;
	logic [IB:0]          e_pos;
	phase_t               e_phase;
	logic [IB-1:0]        e_run, e_pend, e_emit_end, e_count;
	logic                 e_have_emit, e_halted;

	logic [IB:0]   len_eff, len_m1;
	logic          skip, last_smp;
	logic [IB-1:0] p;
	logic          above_up, above_lo, prev_le;
	logic [IB:0]   run_inc;
	phase_t        phase_mid, phase_n;
	logic [IB-1:0] run_n, pend_n;
	logic          close_early, do_close, emit;
	logic [IB-1:0] close_idx;
	logic [IB+1:0] end_sum;
	logic [IB-1:0] end_v, count_inc;
	logic          limit;

	assign advance = valid_s1 && (!out_valid_q || windows.ready);
	assign samples.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_comb begin
		e_prev      = rs_s1 ? '0 : prev_q;
		e_have_prev = rs_s1 ? 1'b0 : have_prev_q;
		e_pos       = rs_s1 ? '0 : pos_q;
		e_phase     = rs_s1 ? PH_IDLE : phase_q;
		e_run       = rs_s1 ? '0 : run_q;
		e_pend      = rs_s1 ? '0 : pend_q;
		e_have_emit = rs_s1 ? 1'b0 : have_emit_q;
		e_emit_end  = rs_s1 ? '0 : emit_end_q;
		e_count     = rs_s1 ? '0 : count_q;
		e_halted    = rs_s1 ? 1'b0 : halted_q;
	end

	always_comb begin
		// lengths beyond the index range act as the full range
		len_eff = rec_len_q[IB] ? {1'b1, {IB{1'b0}}} : rec_len_q;
		len_m1 = len_eff - 1'b1;
		skip = e_halted || (e_pos >= len_eff);
		last_smp = (e_pos == len_m1);
		p = e_pos[IB-1:0];
		above_up = sample_s1 > upper_q;
		above_lo = sample_s1 > lower_q;
		prev_le = e_prev <= upper_q;
		run_inc = {1'b0, e_run} + 1'b1;

		phase_mid = e_phase;
		run_n = e_run;
		pend_n = e_pend;
		close_early = 1'b0;
		case (e_phase)
			PH_IDLE: begin
				if (e_have_prev && prev_le && above_up) begin
					pend_n = (p > pre_q) ? p - pre_q : '0;
					if (debounce_q) begin
						run_n = {{(IB-1){1'b0}}, 1'b1};
						phase_mid = ({{IB{1'b0}}, 1'b1} >= {1'b0, min_run_q}) ? PH_LOWER
							: PH_DEBOUNCE;
					end else begin
						phase_mid = PH_UPPER;
					end
				end
			end
			PH_DEBOUNCE: begin
				if (above_up) begin
					run_n = run_inc[IB-1:0];
					if (run_inc >= {1'b0, min_run_q})
						phase_mid = PH_LOWER;
				end else begin
					phase_mid = PH_IDLE;
				end
			end
			PH_UPPER: begin
				if (!above_up) begin
					if (above_lo)
						phase_mid = PH_LOWER;
					else
						close_early = 1'b1;
				end
			end
			default: begin
				if (!above_lo)
					close_early = 1'b1;
			end
		endcase

		// at most one close per sample: an early close leaves the phase idle
		do_close = !skip && (close_early ||
			(last_smp && (phase_mid == PH_UPPER || phase_mid == PH_LOWER)));
		close_idx = close_early ? p - 1'b1 : p;
		end_sum = {2'b00, close_idx} + {2'b00, post_q};
		end_v = (end_sum > {1'b0, len_m1}) ? len_m1[IB-1:0] : end_sum[IB-1:0];
		emit = do_close && (!e_have_emit || pend_n > e_emit_end);
		count_inc = e_count + 1'b1;
		limit = (max_win_q != '0) && (count_inc >= max_win_q);

		phase_n = (close_early || last_smp) ? PH_IDLE : phase_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			lower_q <= '0;
			pre_q <= '0;
			post_q <= '0;
			debounce_q <= 1'b0;
			min_run_q <= '0;
			max_win_q <= '0;
			rec_len_q <= {1'b1, {IB{1'b0}}};
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_UPPER:    upper_q <= cfg.data[SB-1:0];
				REG_LOWER:    lower_q <= cfg.data[SB-1:0];
				REG_PRE:      pre_q <= cfg.data[IB-1:0];
				REG_POST:     post_q <= cfg.data[IB-1:0];
				REG_DEBOUNCE: debounce_q <= cfg.data[0];
				REG_MIN_RUN:  min_run_q <= cfg.data[IB-1:0];
				REG_MAX_WIN:  max_win_q <= cfg.data[IB-1:0];
				REG_REC_LEN:  rec_len_q <= cfg.data[IB:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (samples.ready)
			valid_s1 <= samples.valid;
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample;
			rs_s1 <= samples.record_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_prev_q <= 1'b0;
			pos_q <= '0;
			phase_q <= PH_IDLE;
			run_q <= '0;
			pend_q <= '0;
			have_emit_q <= 1'b0;
			emit_end_q <= '0;
			count_q <= '0;
			halted_q <= 1'b0;
		end else if (advance) begin
			if (skip) begin
				// ignored sample: only a record restart takes effect
				prev_q <= e_prev;
				have_prev_q <= e_have_prev;
				pos_q <= e_pos;
				phase_q <= e_phase;
				run_q <= e_run;
				pend_q <= e_pend;
				have_emit_q <= e_have_emit;
				emit_end_q <= e_emit_end;
				count_q <= e_count;
				halted_q <= e_halted;
			end else begin
				prev_q <= sample_s1;
				have_prev_q <= 1'b1;
				pos_q <= e_pos + 1'b1;
				phase_q <= phase_n;
				run_q <= run_n;
				pend_q <= pend_n;
				have_emit_q <= e_have_emit || emit;
				emit_end_q <= emit ? end_v : e_emit_end;
				count_q <= emit ? count_inc : e_count;
				halted_q <= emit && limit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= emit;
		else if (windows.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			wstart_q <= pend_n;
			wend_q <= end_v;
			wnum_q <= e_count;
			limit_q <= limit;
		end
	end

	assign windows.valid = out_valid_q;
	assign windows.window_start = wstart_q;
	assign windows.window_end = wend_q;
	assign windows.window_number = wnum_q;
	assign windows.limit_reached = limit_q;

`include "double_threshold_trigger_assert.svh"

	`DTT_ASSERT_NOW(a_halt_idle, clk, arst_n, halted_q, phase_q == PH_IDLE)
	`DTT_ASSERT_NOW(a_no_overrun, clk, arst_n, out_valid_q && !windows.ready, !advance)
	`DTT_ASSERT_NOW(a_start_le_end, clk, arst_n, out_valid_q, wstart_q <= wend_q)
	`DTT_ASSERT_NEXT(a_count_moves, clk, arst_n, advance && emit, count_q != '0)

endmodule
